// ----- rtl/bds_pkg.sv -----
package bds_pkg;

    // configuration port
    localparam int CFG_DATA_W  = 13;
    localparam int CFG_INDEX_W = 2;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_SOURCE_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SOURCE_HEIGHT = 2'd1;

    // frame size after reset, before clamping to the build maximum
    localparam int DIM_RESET = 4096;

    typedef struct packed {
        logic [7:0] alpha;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pixel_t;

    // position of the item now at the input
    typedef struct packed {
        logic pair_done;   // odd column, completes a horizontal pair
        logic row_odd;     // second row of a 2x2 block
        logic frame_last;  // gives the last output of the frame
    } pos_t;

    // per-channel truncating average
    function automatic pixel_t avg_pixel(input pixel_t a, input pixel_t b);
        logic [8:0] sum_b;
        logic [8:0] sum_g;
        logic [8:0] sum_r;
        logic [8:0] sum_a;
        pixel_t     res;
        sum_b = {1'b0, a.blue}  + {1'b0, b.blue};
        sum_g = {1'b0, a.green} + {1'b0, b.green};
        sum_r = {1'b0, a.red}   + {1'b0, b.red};
        sum_a = {1'b0, a.alpha} + {1'b0, b.alpha};
        res.blue  = sum_b[8:1];
        res.green = sum_g[8:1];
        res.red   = sum_r[8:1];
        res.alpha = sum_a[8:1];
        return res;
    endfunction

endpackage

// ----- rtl/bds_cfg.sv -----
module bds_cfg #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_write_en,
    input  logic [bds_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [bds_pkg::CFG_DATA_W-1:0]      cfg_data,
    output logic [$clog2(MAX_WIDTH):0]          width_reg,
    output logic [$clog2(MAX_HEIGHT):0]         height_reg,
    output logic                                restart
);

    localparam int WW    = $clog2(MAX_WIDTH) + 1;
    localparam int HW    = $clog2(MAX_HEIGHT) + 1;
    localparam int CMP_W = (bds_pkg::CFG_DATA_W > WW) ? bds_pkg::CFG_DATA_W : WW;
    localparam int CMP_H = (bds_pkg::CFG_DATA_W > HW) ? bds_pkg::CFG_DATA_W : HW;
    localparam int RESET_W = (bds_pkg::DIM_RESET > MAX_WIDTH)  ? MAX_WIDTH
                                                               : bds_pkg::DIM_RESET;
    localparam int RESET_H = (bds_pkg::DIM_RESET > MAX_HEIGHT) ? MAX_HEIGHT
                                                               : bds_pkg::DIM_RESET;

    logic [CMP_W-1:0] data_w;
    logic [CMP_H-1:0] data_h;
    logic [WW-1:0]    width_clamped;
    logic [HW-1:0]    height_clamped;
    logic             wr_width;
    logic             wr_height;
    logic [WW-1:0]    width_next;
    logic [HW-1:0]    height_next;

    // decode the write
    assign wr_width  = cfg_write_en && (cfg_index == bds_pkg::CFG_SOURCE_WIDTH);
    assign wr_height = cfg_write_en && (cfg_index == bds_pkg::CFG_SOURCE_HEIGHT);
    assign restart   = wr_width || wr_height;

    // zero acts as one, large values saturate at the build maximum
    always_comb begin
        data_w = CMP_W'(cfg_data);
        if (data_w == '0) begin
            width_clamped = WW'(1);
        end else if (data_w > CMP_W'(MAX_WIDTH)) begin
            width_clamped = WW'(MAX_WIDTH);
        end else begin
            width_clamped = data_w[WW-1:0];
        end
    end

    always_comb begin
        data_h = CMP_H'(cfg_data);
        if (data_h == '0) begin
            height_clamped = HW'(1);
        end else if (data_h > CMP_H'(MAX_HEIGHT)) begin
            height_clamped = HW'(MAX_HEIGHT);
        end else begin
            height_clamped = data_h[HW-1:0];
        end
    end

    assign width_next  = wr_width  ? width_clamped  : width_reg;
    assign height_next = wr_height ? height_clamped : height_reg;

    // size registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WW'(RESET_W);
            height_reg <= HW'(RESET_H);
        end else begin
            width_reg  <= width_next;
            height_reg <= height_next;
        end
    end

endmodule

// ----- rtl/bds_scan.sv -----
module bds_scan #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                                        aclk,
    input  logic                                        aresetn,
    input  logic                                        restart,
    input  logic                                        step,
    input  logic [$clog2(MAX_WIDTH):0]                  width,
    input  logic [$clog2(MAX_HEIGHT):0]                 height,
    output bds_pkg::pos_t                               pos,
    output logic [$clog2((MAX_WIDTH + 1) / 2) + ((MAX_WIDTH + 1) / 2 == 1 ? 1 : 0) - 1:0]
                                                        store_index
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam int DEPTH = (MAX_WIDTH + 1) / 2;
    localparam int IDX_W = $clog2(DEPTH) + ((DEPTH == 1) ? 1 : 0);

    logic [COL_W-1:0] column_count_reg;
    logic [COL_W-1:0] column_count_next;
    logic [ROW_W-1:0] row_count_reg;
    logic [ROW_W-1:0] row_count_next;
    logic [COL_W:0]   col_ext;
    logic [COL_W:0]   col_plus;
    logic [ROW_W:0]   row_plus;
    logic [COL_W:0]   width_even;
    logic [ROW_W:0]   height_even;

    assign col_ext     = {1'b0, column_count_reg};
    assign col_plus    = col_ext + (COL_W + 1)'(1);
    assign row_plus    = {1'b0, row_count_reg} + (ROW_W + 1)'(1);
    assign width_even  = {width[COL_W:1], 1'b0};
    assign height_even = {height[ROW_W:1], 1'b0};

    // position flags of the current item
    assign pos.pair_done  = column_count_reg[0];
    assign pos.row_odd    = row_count_reg[0];
    assign pos.frame_last = (col_plus == width_even) && (row_plus == height_even);
    assign store_index    = col_ext[IDX_W:1];

    // raster counters
    always_comb begin
        column_count_next = column_count_reg;
        row_count_next    = row_count_reg;
        priority if (restart) begin
            column_count_next = '0;
            row_count_next    = '0;
        end else if (step) begin
            if (col_plus >= width) begin
                column_count_next = '0;
                row_count_next    = (row_plus >= height) ? '0 : row_plus[ROW_W-1:0];
            end else begin
                column_count_next = col_plus[COL_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            column_count_reg <= '0;
            row_count_reg    <= '0;
        end else begin
            column_count_reg <= column_count_next;
            row_count_reg    <= row_count_next;
        end
    end

endmodule

// ----- rtl/bds_line_store.sv -----
module bds_line_store #(
    parameter int DEPTH = 2048,
    parameter int IDX_W = 11
) (
    input  logic                 aclk,
    input  logic                 wr_en,
    input  logic [IDX_W-1:0]     wr_index,
    input  bds_pkg::pixel_t      wr_data,
    input  logic                 rd_en,
    input  logic [IDX_W-1:0]     rd_index,
    output bds_pkg::pixel_t      rd_data_reg
);

    bds_pkg::pixel_t mem [0:DEPTH-1];

    // pair averages of the last even row
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_index] <= wr_data;
        end
    end

    // registered read, held while the consumer stalls
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_index];
        end
    end

endmodule

// ----- rtl/box_downsample_2x2_bgra.sv -----
// an accepted odd-row, odd-column pixel goes through s1_pair_reg, then out_reg
// throughput: one pixel per cycle unless stalled, one output per 2x2 source block
// the line store is one write and one read port, each used at most once per pixel
// s_ready drops only while both pipeline registers hold items and m_ready is low
// reset (aresetn, synchronous, active low): size registers to 4096 (clamped to
// the build maximum), counters to zero, pipeline empty; the line store is not cleared
module box_downsample_2x2_bgra #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration
    input  logic                                cfg_write_en,
    input  logic [bds_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [bds_pkg::CFG_DATA_W-1:0]      cfg_data,
    // source pixels
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [7:0]                          s_pixel_blue,
    input  logic [7:0]                          s_pixel_green,
    input  logic [7:0]                          s_pixel_red,
    input  logic [7:0]                          s_pixel_alpha,
    // output pixels
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [7:0]                          m_out_blue,
    output logic [7:0]                          m_out_green,
    output logic [7:0]                          m_out_red,
    output logic [7:0]                          m_out_alpha,
    output logic                                m_frame_last
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam int DEPTH = (MAX_WIDTH + 1) / 2;
    localparam int IDX_W = $clog2(DEPTH) + ((DEPTH == 1) ? 1 : 0);

    logic [COL_W:0]      width;
    logic [ROW_W:0]      height;
    logic                restart;
    bds_pkg::pos_t       pos;
    logic [IDX_W-1:0]    store_index;

    bds_pkg::pixel_t     in_pixel;
    bds_pkg::pixel_t     held_reg;
    bds_pkg::pixel_t     held_next;
    bds_pkg::pixel_t     pair;
    bds_pkg::pixel_t     above;
    bds_pkg::pixel_t     s1_pair_reg;
    bds_pkg::pixel_t     s1_pair_next;
    logic                s1_last_reg;
    logic                s1_last_next;
    logic                s1_valid_reg;
    logic                s1_valid_next;
    bds_pkg::pixel_t     out_reg;
    bds_pkg::pixel_t     out_next;
    logic                out_last_reg;
    logic                out_last_next;
    logic                out_valid_reg;
    logic                out_valid_next;

    logic                accept;
    logic                out_advance;
    logic                wr_en;
    logic                rd_en;

    bds_cfg #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_cfg (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .width_reg    (width),
        .height_reg   (height),
        .restart      (restart)
    );

    bds_scan #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_scan (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .restart     (restart),
        .step        (accept),
        .width       (width),
        .height      (height),
        .pos         (pos),
        .store_index (store_index)
    );

    bds_line_store #(
        .DEPTH (DEPTH),
        .IDX_W (IDX_W)
    ) u_line_store (
        .aclk        (aclk),
        .wr_en       (wr_en),
        .wr_index    (store_index),
        .wr_data     (pair),
        .rd_en       (rd_en),
        .rd_index    (store_index),
        .rd_data_reg (above)
    );

    // handshake: the pipeline moves whenever the output register frees up
    assign out_advance = !out_valid_reg || m_ready;
    assign s_ready     = !s1_valid_reg || out_advance;
    assign accept      = s_valid && s_ready;

    assign in_pixel.blue  = s_pixel_blue;
    assign in_pixel.green = s_pixel_green;
    assign in_pixel.red   = s_pixel_red;
    assign in_pixel.alpha = s_pixel_alpha;

    // horizontal pair average
    assign pair  = bds_pkg::avg_pixel(held_reg, in_pixel);
    assign wr_en = accept && pos.pair_done && !pos.row_odd;
    assign rd_en = accept && pos.pair_done && pos.row_odd;

    // even-column pixel waits for its partner
    assign held_next = (accept && !pos.pair_done) ? in_pixel : held_reg;

    // first stage: pair average and frame mark, line store read in flight
    always_comb begin
        s1_pair_next  = s1_pair_reg;
        s1_last_next  = s1_last_reg;
        s1_valid_next = s1_valid_reg;
        if (rd_en) begin
            s1_pair_next  = pair;
            s1_last_next  = pos.frame_last;
            s1_valid_next = 1'b1;
        end else if (out_advance) begin
            s1_valid_next = 1'b0;
        end
    end

    // output stage: vertical average
    always_comb begin
        out_next       = out_reg;
        out_last_next  = out_last_reg;
        out_valid_next = out_valid_reg;
        if (out_advance) begin
            out_valid_next = s1_valid_reg;
            if (s1_valid_reg) begin
                out_next      = bds_pkg::avg_pixel(above, s1_pair_reg);
                out_last_next = s1_last_reg;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        held_reg     <= held_next;
        s1_pair_reg  <= s1_pair_next;
        s1_last_reg  <= s1_last_next;
        out_reg      <= out_next;
        out_last_reg <= out_last_next;
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_out_blue   = out_reg.blue;
    assign m_out_green  = out_reg.green;
    assign m_out_red    = out_reg.red;
    assign m_out_alpha  = out_reg.alpha;
    assign m_frame_last = out_last_reg;

endmodule

// ----- rtl/bds_checker.sv -----
module bds_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_valid,
    input logic                                s_ready,
    input logic                                m_valid,
    input logic                                m_ready,
    input logic [7:0]                          m_out_blue,
    input logic [7:0]                          m_out_green,
    input logic [7:0]                          m_out_red,
    input logic [7:0]                          m_out_alpha,
    input logic                                m_frame_last
);

    logic in_item;

    assign in_item = s_valid && s_ready;

    // output is empty right after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid after reset");

    // a stalled output item holds its payload
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_out_blue) && $stable(m_out_green)
            && $stable(m_out_red) && $stable(m_out_alpha) && $stable(m_frame_last)))
        else $error("output item changed while stalled");

    // a ready sink never stalls the source
    a_no_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        m_ready |-> s_ready)
        else $error("input stalled while output is taken");

    // the pipeline drains: idle cycles with an empty output leave nothing behind
    a_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (!in_item && !m_valid) ##1 (!in_item && !m_valid) |=> !m_valid)
        else $error("output item appeared without a source item");

endmodule

bind box_downsample_2x2_bgra bds_checker u_bds_checker (.*);
